// File: sv/kpgc_pkg.sv
`default_nettype none
package kpgc_pkg;

    localparam int MAX_KEYS_DEF = 8;
    // The PIN register holds this many 4-bit keys
    localparam int PIN_KEYS_MAX = 8;
    localparam int KEY_W        = 4;
    localparam int LEN_W        = 4;
    localparam int TICK_W       = 16;
    localparam int DIST_W       = 10;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [KEY_W-1:0]  KEY_STAR        = 4'd14;
    localparam logic [KEY_W-1:0]  KEY_HASH        = 4'd15;
    localparam logic [DIST_W-1:0] ECHO_TIMEOUT_CM = 10'd999;

    localparam logic [31:0]       PIN_KEYS_RST   = 32'h0000_1234;
    localparam logic [LEN_W-1:0]  PIN_LENGTH_RST = 4'd4;
    localparam logic [TICK_W-1:0] OPEN_TICKS_RST = 16'd8000;
    localparam logic [DIST_W-1:0] CLEAR_DIST_RST = 10'd20;

    typedef enum logic [1:0] {
        KIND_KEY    = 2'd0,
        KIND_TICK   = 2'd1,
        KIND_REMOTE = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIN_KEYS   = 2'd0,
        CFG_PIN_LENGTH = 2'd1,
        CFG_OPEN_TICKS = 2'd2,
        CFG_CLEAR_DIST = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        EV_NONE         = 4'd0,
        EV_PIN_GRANT    = 4'd1,
        EV_REMOTE_GRANT = 4'd2,
        EV_DENIED       = 4'd3,
        EV_AUTO_CLOSE   = 4'd4,
        EV_REMOTE_CLOSE = 4'd5,
        EV_OBSTACLE     = 4'd6,
        EV_CLEARED      = 4'd7,
        EV_KEY_STORED   = 4'd8
    } t_event;

    typedef struct packed {
        logic [31:0]       pin_keys;
        logic [LEN_W-1:0]  pin_length;
        logic [TICK_W-1:0] open_ticks;
        logic [DIST_W-1:0] clear_dist;
    } t_cfg;

    typedef struct packed {
        logic             gate_is_open;
        t_event           event_code;
        logic [KEY_W-1:0] keys_entered;
    } t_result;

endpackage
`default_nettype wire

// File: sv/keypad_pin_gate_controller.sv
// Channel | Direction | Signals                                       | Accepted when
// in      | sink      | i_in_valid, o_in_ready, i_in_kind, i_in_key_code,
//         |           | i_in_remote_open, i_in_distance_cm           | valid & ready
// out     | source    | o_out_valid, i_out_ready, o_out_gate_is_open,
//         |           | o_out_event_code, o_out_keys_entered         | valid & ready
// cfg     | sink      | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | valid & ready
//
// One transaction per cycle sustained while the output is not stalled; a result passes
// through the input register and then the result register before it is offered.
// All item work is a single combinational pass from input register to result
// register, with the lock state updated in the same cycle.
// Synchronous active-low reset clears control state, configuration to defaults.
// A stalled output holds the result register; the input register takes one more
// transaction, then o_in_ready drops until the output drains.
// Configuration writes are always taken (o_cfg_ready high).
`default_nettype none
module keypad_pin_gate_controller
    import kpgc_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [1:0]            i_in_kind,
    input  wire logic [KEY_W-1:0]      i_in_key_code,
    input  wire logic                  i_in_remote_open,
    input  wire logic [DIST_W-1:0]     i_in_distance_cm,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic                       o_out_gate_is_open,
    output logic [3:0]                 o_out_event_code,
    output logic [KEY_W-1:0]           o_out_keys_entered,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic              r_in_valid;
    logic [1:0]        r_kind;
    logic [KEY_W-1:0]  r_key_code;
    logic              r_remote_open;
    logic [DIST_W-1:0] r_distance_cm;
    logic              r_out_valid;
    t_result           r_result;

    logic    advance;
    t_cfg    cfg;
    t_result result;

    assign o_cfg_ready = 1'b1;
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;

    kpgc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_idx   (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kpgc_core #(
        .MAX_KEYS (MAX_KEYS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (advance),
        .i_kind        (r_kind),
        .i_key_code    (r_key_code),
        .i_remote_open (r_remote_open),
        .i_distance_cm (r_distance_cm),
        .i_cfg         (cfg),
        .o_result      (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind        <= i_in_kind;
            r_key_code    <= i_in_key_code;
            r_remote_open <= i_in_remote_open;
            r_distance_cm <= i_in_distance_cm;
        end
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_gate_is_open = r_result.gate_is_open;
    assign o_out_event_code   = r_result.event_code;
    assign o_out_keys_entered = r_result.keys_entered;

    property p_grant_opens;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_result.event_code == EV_PIN_GRANT
                         || r_result.event_code == EV_REMOTE_GRANT
                         || r_result.event_code == EV_OBSTACLE))
            |-> r_result.gate_is_open;
    endproperty
    a_grant_opens: assert property (p_grant_opens)
        else $error("open event with gate reported closed");

    property p_close_closes;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_result.event_code == EV_AUTO_CLOSE
                         || r_result.event_code == EV_REMOTE_CLOSE))
            |-> !r_result.gate_is_open;
    endproperty
    a_close_closes: assert property (p_close_closes)
        else $error("close event with gate reported open");

    property p_enter_clears;
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (r_result.event_code == EV_PIN_GRANT
                         || r_result.event_code == EV_DENIED
                         || r_result.event_code == EV_CLEARED))
            |-> (r_result.keys_entered == '0);
    endproperty
    a_enter_clears: assert property (p_enter_clears)
        else $error("key buffer not emptied on enter or clear");

    property p_stall_holds_in;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid;
    endproperty
    a_stall_holds_in: assert property (p_stall_holds_in)
        else $error("input register dropped a stalled transaction");

endmodule
`default_nettype wire

// File: sv/kpgc_cfg_regs.sv
`default_nettype none
module kpgc_cfg_regs
    import kpgc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr,
    input  wire logic [CFG_IDX_W-1:0]  i_idx,
    input  wire logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pin_keys   <= PIN_KEYS_RST;
            r_cfg.pin_length <= PIN_LENGTH_RST;
            r_cfg.open_ticks <= OPEN_TICKS_RST;
            r_cfg.clear_dist <= CLEAR_DIST_RST;
        end else if (i_wr) begin
            unique case (t_cfg_idx'(i_idx))
                CFG_PIN_KEYS:   r_cfg.pin_keys   <= i_data;
                CFG_PIN_LENGTH: r_cfg.pin_length <= i_data[LEN_W-1:0];
                CFG_OPEN_TICKS: r_cfg.open_ticks <= i_data[TICK_W-1:0];
                CFG_CLEAR_DIST: r_cfg.clear_dist <= i_data[DIST_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// File: sv/kpgc_core.sv
`default_nettype none
module kpgc_core
    import kpgc_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_step,
    input  wire logic [1:0]        i_kind,
    input  wire logic [KEY_W-1:0]  i_key_code,
    input  wire logic              i_remote_open,
    input  wire logic [DIST_W-1:0] i_distance_cm,
    input  t_cfg                   i_cfg,
    output t_result                o_result
);

    localparam int KCW      = $clog2(MAX_KEYS + 1);
    localparam int KIW      = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CMP_KEYS = (MAX_KEYS < PIN_KEYS_MAX) ? MAX_KEYS : PIN_KEYS_MAX;
    localparam int CW       = (KCW > LEN_W) ? KCW : LEN_W;

    logic [KEY_W-1:0]  r_pin_buf [MAX_KEYS];
    logic [KCW-1:0]    r_key_count, n_key_count;
    logic              r_gate_open, n_gate_open;
    logic [TICK_W-1:0] r_elapsed, n_elapsed;

    logic              pin_match;
    logic              key_store;
    logic [TICK_W-1:0] elapsed_inc;
    t_event            ev;

    always_comb begin
        pin_match = (i_cfg.pin_length <= LEN_W'(PIN_KEYS_MAX))
                 && (CW'(r_key_count) == CW'(i_cfg.pin_length));
        for (int i = 0; i < CMP_KEYS; i++) begin
            if ((KCW'(i) < r_key_count)
                && (r_pin_buf[i] != i_cfg.pin_keys[KEY_W*i +: KEY_W])) begin
                pin_match = 1'b0;
            end
        end
    end

    assign elapsed_inc = (r_elapsed != '1) ? r_elapsed + 1'b1 : r_elapsed;

    always_comb begin
        n_key_count = r_key_count;
        n_gate_open = r_gate_open;
        n_elapsed   = r_elapsed;
        key_store   = 1'b0;
        ev          = EV_NONE;
        unique case (i_kind)
            KIND_KEY: begin
                if (i_key_code == KEY_HASH) begin
                    if (pin_match) begin
                        n_gate_open = 1'b1;
                        n_elapsed   = '0;
                        ev          = EV_PIN_GRANT;
                    end else begin
                        ev = EV_DENIED;
                    end
                    n_key_count = '0;
                end else if (i_key_code == KEY_STAR) begin
                    n_key_count = '0;
                    ev          = EV_CLEARED;
                end else if (r_key_count < KCW'(MAX_KEYS)) begin
                    key_store   = 1'b1;
                    n_key_count = r_key_count + 1'b1;
                    ev          = EV_KEY_STORED;
                end
            end
            KIND_TICK: begin
                if (r_gate_open) begin
                    n_elapsed = elapsed_inc;
                    if (elapsed_inc >= i_cfg.open_ticks) begin
                        n_elapsed = '0;
                        if (i_distance_cm > i_cfg.clear_dist
                            || i_distance_cm >= ECHO_TIMEOUT_CM) begin
                            n_gate_open = 1'b0;
                            ev          = EV_AUTO_CLOSE;
                        end else begin
                            ev = EV_OBSTACLE;
                        end
                    end
                end
            end
            KIND_REMOTE: begin
                if (i_remote_open && !r_gate_open) begin
                    n_gate_open = 1'b1;
                    n_elapsed   = '0;
                    ev          = EV_REMOTE_GRANT;
                end else if (!i_remote_open && r_gate_open) begin
                    n_gate_open = 1'b0;
                    n_elapsed   = '0;
                    ev          = EV_REMOTE_CLOSE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_gate_open <= 1'b0;
            r_elapsed   <= '0;
        end else if (i_step) begin
            r_key_count <= n_key_count;
            r_gate_open <= n_gate_open;
            r_elapsed   <= n_elapsed;
        end
    end

    // Buffer entries at or above the count are never compared
    always_ff @(posedge i_clk) begin
        if (i_step && key_store) begin
            r_pin_buf[r_key_count[KIW-1:0]] <= i_key_code;
        end
    end

    assign o_result.gate_is_open = n_gate_open;
    assign o_result.event_code   = ev;
    assign o_result.keys_entered = KEY_W'(n_key_count);

    property p_count_bounded;
        @(posedge i_clk) disable iff (!i_rst_n)
        r_key_count <= KCW'(MAX_KEYS);
    endproperty
    a_count_bounded: assert property (p_count_bounded)
        else $error("key count beyond buffer depth");

    property p_closed_elapsed_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        !r_gate_open |-> (r_elapsed == '0);
    endproperty
    a_closed_elapsed_zero: assert property (p_closed_elapsed_zero)
        else $error("elapsed count running while gate closed");

endmodule
`default_nettype wire

// File: tb/keypad_pin_gate_controller_tb.sv
`timescale 1ns / 1ps

module keypad_pin_gate_controller_tb;
    import kpgc_pkg::*;

    // kind value the block must ignore
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 230;
    localparam int HOLD_CYCLES = 300;
    localparam int NUM_PHASES  = 8;

    typedef enum int {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY,
        RX_EVERY3
    } t_rx_mode;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [1:0]            i_in_kind = '0;
    logic [KEY_W-1:0]      i_in_key_code = '0;
    logic                  i_in_remote_open = 1'b0;
    logic [DIST_W-1:0]     i_in_distance_cm = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_out_gate_is_open;
    logic [3:0]            o_out_event_code;
    logic [KEY_W-1:0]      o_out_keys_entered;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    keypad_pin_gate_controller u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_in_kind          (i_in_kind),
        .i_in_key_code      (i_in_key_code),
        .i_in_remote_open   (i_in_remote_open),
        .i_in_distance_cm   (i_in_distance_cm),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_gate_is_open (o_out_gate_is_open),
        .o_out_event_code   (o_out_event_code),
        .o_out_keys_entered (o_out_keys_entered),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    // lock configuration and state as the testbench sees it
    logic [31:0]       lk_pin_keys;
    logic [LEN_W-1:0]  lk_pin_len;
    logic [TICK_W-1:0] lk_open_ticks;
    logic [DIST_W-1:0] lk_clear;
    logic [KEY_W-1:0]  lk_buf [MAX_KEYS_DEF];
    logic [LEN_W-1:0]  lk_count;
    logic              lk_open;
    logic [TICK_W-1:0] lk_elapsed;

    t_result lock_results_q [$];

    int err_count    = 0;
    int items_sent   = 0;
    int results_seen = 0;
    int burst_left   = 0;

    int       hold_req  = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    t_rx_mode rx_mode   = RX_STEADY;
    int       rx_left   = 0;
    int       rx_phase  = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic t_result predict_lock(input logic [1:0] kind,
                                             input logic [KEY_W-1:0] key,
                                             input logic ropen,
                                             input logic [DIST_W-1:0] dist_cm);
        t_result r;
        t_event  ev;
        logic    pin_ok;
        int      i;
        ev = EV_NONE;
        case (kind)
            KIND_KEY: begin
                if (key == KEY_HASH) begin
                    pin_ok = (lk_pin_len <= LEN_W'(PIN_KEYS_MAX)) && (lk_count == lk_pin_len);
                    for (i = 0; i < PIN_KEYS_MAX; i++) begin
                        if (i < int'(lk_count) && lk_buf[i] != lk_pin_keys[4*i +: 4])
                            pin_ok = 1'b0;
                    end
                    if (pin_ok) begin
                        lk_open    = 1'b1;
                        lk_elapsed = '0;
                        ev         = EV_PIN_GRANT;
                    end else begin
                        ev = EV_DENIED;
                    end
                    lk_count = '0;
                end else if (key == KEY_STAR) begin
                    lk_count = '0;
                    ev       = EV_CLEARED;
                end else if (int'(lk_count) < MAX_KEYS_DEF) begin
                    lk_buf[lk_count] = key;
                    lk_count         = lk_count + 1'b1;
                    ev               = EV_KEY_STORED;
                end
            end
            KIND_TICK: begin
                if (lk_open) begin
                    if (lk_elapsed != '1)
                        lk_elapsed = lk_elapsed + 1'b1;
                    if (lk_elapsed >= lk_open_ticks) begin
                        if (dist_cm > lk_clear || dist_cm >= ECHO_TIMEOUT_CM) begin
                            lk_open    = 1'b0;
                            lk_elapsed = '0;
                            ev         = EV_AUTO_CLOSE;
                        end else begin
                            lk_elapsed = '0;
                            ev         = EV_OBSTACLE;
                        end
                    end
                end
            end
            KIND_REMOTE: begin
                if (ropen && !lk_open) begin
                    lk_open    = 1'b1;
                    lk_elapsed = '0;
                    ev         = EV_REMOTE_GRANT;
                end else if (!ropen && lk_open) begin
                    lk_open    = 1'b0;
                    lk_elapsed = '0;
                    ev         = EV_REMOTE_CLOSE;
                end
            end
            default: ;
        endcase
        r.gate_is_open = lk_open;
        r.event_code   = ev;
        r.keys_entered = lk_count;
        return r;
    endfunction

    function automatic logic [31:0] rand_pin();
        logic [31:0] p;
        int          i;
        for (i = 0; i < PIN_KEYS_MAX; i++)
            p[4*i +: 4] = KEY_W'($urandom_range(0, 13));
        return p;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    // one input transaction; called at a falling edge, returns at a falling edge
    task automatic offer(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                         input logic ropen, input logic [DIST_W-1:0] dist_cm);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_in_valid       <= 1'b1;
        i_in_kind        <= kind;
        i_in_key_code    <= key;
        i_in_remote_open <= ropen;
        i_in_distance_cm <= dist_cm;
        do @(posedge i_clk); while (!o_in_ready);
        lock_results_q.push_back(predict_lock(kind, key, ropen, dist_cm));
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic press(input logic [KEY_W-1:0] key);
        offer(KIND_KEY, key, 1'($urandom), DIST_W'($urandom));
    endtask

    task automatic tick(input logic [DIST_W-1:0] dist_cm);
        offer(KIND_TICK, KEY_W'($urandom), 1'($urandom), dist_cm);
    endtask

    task automatic remote(input logic ropen);
        offer(KIND_REMOTE, KEY_W'($urandom), ropen, DIST_W'($urandom));
    endtask

    // type the configured PIN, optionally with one wrong or one extra key
    task automatic enter_pin(input bit corrupt);
        int               n;
        int               bad;
        int               i;
        logic [KEY_W-1:0] k;
        n   = (lk_pin_len > LEN_W'(PIN_KEYS_MAX)) ? PIN_KEYS_MAX : int'(lk_pin_len);
        bad = corrupt ? $urandom_range(0, n) : -1;
        for (i = 0; i < n; i++) begin
            k = lk_pin_keys[4*i +: 4];
            if (k >= KEY_STAR)
                k = KEY_W'($urandom_range(0, 13));
            if (i == bad)
                k = (k == 4'd13) ? 4'd0 : k + 1'b1;
            press(k);
        end
        if (bad == n)
            press(KEY_W'($urandom_range(0, 13)));
        press(KEY_HASH);
    endtask

    // drop valid and wait for every expected result before touching registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (lock_results_q.size() > 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        logic [31:0] mask;
        logic [31:0] noise;
        case (idx)
            CFG_PIN_KEYS:   mask = '1;
            CFG_PIN_LENGTH: mask = 32'((1 << LEN_W) - 1);
            CFG_OPEN_TICKS: mask = 32'((1 << TICK_W) - 1);
            default:        mask = 32'((1 << DIST_W) - 1);
        endcase
        // bits above the register width must be dropped by the block
        noise = $urandom;
        data  = (data & mask) | (noise & ~mask);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_PIN_KEYS:   lk_pin_keys   = data;
            CFG_PIN_LENGTH: lk_pin_len    = data[LEN_W-1:0];
            CFG_OPEN_TICKS: lk_open_ticks = data[TICK_W-1:0];
            default:        lk_clear      = data[DIST_W-1:0];
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_lock_config(input logic [31:0] keys, input int len,
                                    input int ticks, input int clear);
        cfg_write(CFG_PIN_KEYS, keys);
        cfg_write(CFG_PIN_LENGTH, 32'(len));
        cfg_write(CFG_OPEN_TICKS, 32'(ticks));
        cfg_write(CFG_CLEAR_DIST, 32'(clear));
    endtask

    task automatic test_directed_defaults();
        enter_pin(1'b0);
        remote(1'b1);
        tick(DIST_W'(0));
        // grant while already open restarts the timer
        enter_pin(1'b0);
        remote(1'b0);
        tick(DIST_W'(1023));
        remote(1'b0);
        offer(KIND_UNUSED, KEY_HASH, 1'b1, DIST_W'(1023));
        // fill the buffer; the ninth key is dropped
        press(4'd0);
        repeat (8) press(4'd13);
        press(KEY_HASH);
        press(KEY_STAR);
        press(4'd9);
        press(KEY_STAR);
    endtask

    task automatic test_pin_length_edges();
        settle();
        cfg_write(CFG_PIN_LENGTH, 32'd0);
        press(KEY_HASH);
        remote(1'b0);
        press(4'd3);
        press(KEY_HASH);
        settle();
        // a length over eight can never match
        cfg_write(CFG_PIN_KEYS, 32'h0);
        cfg_write(CFG_PIN_LENGTH, 32'd9);
        enter_pin(1'b0);
    endtask

    task automatic test_timer_edges();
        settle();
        cfg_write(CFG_OPEN_TICKS, 32'd0);
        cfg_write(CFG_CLEAR_DIST, 32'd1023);
        remote(1'b1);
        tick(DIST_W'(998));
        tick(ECHO_TIMEOUT_CM);
        settle();
        cfg_write(CFG_CLEAR_DIST, 32'd0);
        remote(1'b1);
        tick(DIST_W'(0));
        tick(DIST_W'(1));
        remote(1'b1);
        remote(1'b0);
    endtask

    task automatic test_random_phases();
        int               ph;
        int               start;
        int               r;
        int               n;
        int               i;
        logic [DIST_W-1:0] d;
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            case (ph)
                0: load_lock_config(rand_pin(), 4, $urandom_range(1, 12),
                                    $urandom_range(0, 1023));
                1: load_lock_config(32'h0, 8, 1, 0);
                2: load_lock_config(32'hFFFF_FFFF, 1, 65535, 1023);
                3: load_lock_config(rand_pin(), 0, $urandom_range(1, 6),
                                    $urandom_range(0, 1023));
                4: load_lock_config(rand_pin(), 15, 2, 500);
                default: load_lock_config(rand_pin(), $urandom_range(1, 8),
                                          $urandom_range(0, 20), $urandom_range(0, 1023));
            endcase
            // hold the output off so the block backs up into its input
            if (ph == 0 || ph == 5)
                hold_req++;
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 30) begin
                    enter_pin($urandom_range(0, 4) == 0);
                end else if (r < 58) begin
                    n = $urandom_range(1, 12);
                    for (i = 0; i < n; i++) begin
                        case ($urandom_range(0, 3))
                            0: d = DIST_W'($urandom_range(0, 1023));
                            1: d = lk_clear;
                            2: d = lk_clear + 1'b1;
                            default: d = DIST_W'($urandom_range(ECHO_TIMEOUT_CM, 1023));
                        endcase
                        tick(d);
                    end
                end else if (r < 70) begin
                    remote(1'($urandom_range(0, 1)));
                end else if (r < 78) begin
                    n = $urandom_range(1, 10);
                    repeat (n) press(KEY_W'($urandom_range(0, 13)));
                    press($urandom_range(0, 1) ? KEY_STAR : KEY_HASH);
                end else begin
                    offer(2'($urandom_range(0, 3)), KEY_W'($urandom), 1'($urandom),
                          DIST_W'($urandom));
                end
            end
        end
    endtask

    // receiver: long hold when asked, otherwise a changing stall pattern
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(5, 60);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_STEADY: i_out_ready <= 1'b1;
                RX_LIGHT:  i_out_ready <= ($urandom_range(0, 9) < 7);
                RX_HEAVY:  i_out_ready <= ($urandom_range(0, 3) == 0);
                default:   i_out_ready <= (rx_phase % 3 == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (lock_results_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with none pending, event %0d",
                                          results_seen, o_out_event_code));
            end else begin
                want = lock_results_q.pop_front();
                if (o_out_gate_is_open !== want.gate_is_open)
                    report_mismatch($sformatf("result %0d gate_is_open: want %0d got %0d",
                                              results_seen, want.gate_is_open,
                                              o_out_gate_is_open));
                if (o_out_event_code !== want.event_code)
                    report_mismatch($sformatf("result %0d event_code: want %0d got %0d",
                                              results_seen, want.event_code,
                                              o_out_event_code));
                if (o_out_keys_entered !== want.keys_entered)
                    report_mismatch($sformatf("result %0d keys_entered: want %0d got %0d",
                                              results_seen, want.keys_entered,
                                              o_out_keys_entered));
            end
            results_seen++;
        end
    end

    initial begin
        lk_pin_keys   = PIN_KEYS_RST;
        lk_pin_len    = PIN_LENGTH_RST;
        lk_open_ticks = OPEN_TICKS_RST;
        lk_clear      = CLEAR_DIST_RST;
        for (int i = 0; i < MAX_KEYS_DEF; i++)
            lk_buf[i] = '0;
        lk_count   = '0;
        lk_open    = 1'b0;
        lk_elapsed = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed_defaults();
        test_pin_length_edges();
        test_timer_edges();
        test_random_phases();
        settle();
        repeat (8) @(negedge i_clk);
        if (err_count == 0 && lock_results_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/kpgc_pkg.sv
sv/kpgc_cfg_regs.sv
sv/kpgc_core.sv
sv/keypad_pin_gate_controller.sv
tb/keypad_pin_gate_controller_tb.sv
